### rtl/stc_pkg.sv
// Shared types, character codes and the keyword table of the source token classifier.
// No dependencies; every module of the block imports this package.
package stc_pkg;

  localparam int NUM_KW  = 22;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // Result kinds
  localparam logic [2:0] KIND_KEYWORD  = 3'd0;
  localparam logic [2:0] KIND_INTEGER  = 3'd1;
  localparam logic [2:0] KIND_REAL     = 3'd2;
  localparam logic [2:0] KIND_IDENT    = 3'd3;
  localparam logic [2:0] KIND_BAD_ID   = 3'd4;
  localparam logic [2:0] KIND_OPERATOR = 3'd5;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] LEN_MAX = 8'hFF;

  localparam logic [NUM_KW-1:0] ALL_CANDS = '1;

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6, 4'd5, 4'd6, 4'd4,
    4'd4, 4'd6, 4'd4, 4'd5, 4'd7, 4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd4
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] token_start;
    logic [7:0] token_length;
    logic [4:0] keyword_number;
    logic       last_result;
  } res_t;

  // One queue entry: all results caused by one input beat
  typedef struct packed {
    res_t res_a;
    res_t res_b;
    logic two;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // Keyword text, left-justified, zero padded to eight characters
  function automatic logic [63:0] kw_word(input logic [4:0] i);
    logic [63:0] w;
    unique case (i)
      5'd0:    w = {"if",       48'h0};
      5'd1:    w = {"else",     32'h0};
      5'd2:    w = {"while",    24'h0};
      5'd3:    w = {"do",       48'h0};
      5'd4:    w = {"break",    24'h0};
      5'd5:    w = "continue";
      5'd6:    w = {"int",      40'h0};
      5'd7:    w = {"double",   16'h0};
      5'd8:    w = {"float",    24'h0};
      5'd9:    w = {"return",   16'h0};
      5'd10:   w = {"char",     32'h0};
      5'd11:   w = {"case",     32'h0};
      5'd12:   w = {"sizeof",   16'h0};
      5'd13:   w = {"long",     32'h0};
      5'd14:   w = {"short",    24'h0};
      5'd15:   w = {"typedef",  8'h0};
      5'd16:   w = {"switch",   16'h0};
      5'd17:   w = "unsigned";
      5'd18:   w = {"void",     32'h0};
      5'd19:   w = {"static",   16'h0};
      5'd20:   w = {"struct",   16'h0};
      5'd21:   w = {"goto",     32'h0};
      default: w = 64'h0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] kw_char(input logic [4:0] i, input logic [2:0] k);
    logic [63:0] w;
    w = kw_word(i) << {k, 3'b000};
    return w[63:56];
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == " " || c == "+" || c == "-" || c == "*" || c == "/" ||
           c == "," || c == ";" || c == ">" || c == "<" || c == "=" ||
           c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
           c == "}";
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == ">" ||
           c == "<" || c == "=";
  endfunction

endpackage

### rtl/stc_front.sv
// Front end: accepts characters, tracks the open token and classifies closed tokens.
// Depends on stc_pkg; pushes one entry per result-bearing beat into stc_queue.
module stc_front
  import stc_pkg::*;
#(
  parameter logic [7:0] POS_CAP = 8'd255
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_t      in_data,
  input  logic     q_full,
  output logic     in_stall,
  output logic     q_push,
  output q_entry_t q_entry
);

  logic [7:0]        line_pos_r, line_pos_nxt;
  logic [7:0]        pend_start_r, pend_start_nxt;
  logic [7:0]        pend_len_r, pend_len_nxt;
  logic              all_dig_r, all_dig_nxt;
  logic              dig_dot_r, dig_dot_nxt;
  logic              seen_dot_r, seen_dot_nxt;
  logic              first_dig_r, first_dig_nxt;
  logic [NUM_KW-1:0] cands_r, cands_nxt;

  // token state after this character, before any flush
  logic [7:0]        upd_start, upd_len;
  logic              upd_all_dig, upd_dig_dot, upd_seen_dot, upd_first_dig;
  logic [NUM_KW-1:0] upd_cands;

  logic accept, delim, oper, dig, dot, tok_valid;
  res_t tok_res, op_res;

  function automatic res_t classify(input logic [NUM_KW-1:0] cands, input logic [7:0] len,
                                    input logic all_d, input logic dd, input logic sd,
                                    input logic fd, input logic [7:0] start);
    res_t r;
    logic found;
    logic [4:0] kwn;
    found = 1'b0;
    kwn   = '0;
    // scan downward so the lowest matching index wins
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (cands[i] && {4'b0, KW_LEN[i]} == len) begin
        found = 1'b1;
        kwn   = 5'(i);
      end
    end
    r.token_start    = start;
    r.token_length   = len;
    r.keyword_number = kwn;
    r.last_result    = 1'b0;
    if (found)          r.kind = KIND_KEYWORD;
    else if (all_d)     r.kind = KIND_INTEGER;
    else if (dd && sd)  r.kind = KIND_REAL;
    else if (!fd)       r.kind = KIND_IDENT;
    else                r.kind = KIND_BAD_ID;
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign delim    = is_delim(in_data.ch);
  assign oper     = is_oper(in_data.ch);
  assign dig      = in_data.ch >= CH_ZERO && in_data.ch <= CH_NINE;
  assign dot      = in_data.ch == CH_DOT;

  always_comb begin
    upd_start     = (pend_len_r == '0) ? line_pos_r : pend_start_r;
    upd_first_dig = (pend_len_r == '0) ? dig : first_dig_r;
    upd_all_dig   = all_dig_r && dig;
    upd_dig_dot   = dig_dot_r && (dig || dot);
    upd_seen_dot  = seen_dot_r || dot;
    upd_len       = (pend_len_r < LEN_MAX) ? pend_len_r + 8'd1 : pend_len_r;
    for (int i = 0; i < NUM_KW; i++) begin
      upd_cands[i] = cands_r[i] && (pend_len_r < {4'b0, KW_LEN[i]}) &&
                     (kw_char(5'(i), pend_len_r[2:0]) == in_data.ch);
    end
  end

  // token result: closed by a delimiter, or flushed at end of line
  always_comb begin
    if (delim) begin
      tok_valid = pend_len_r != '0;
      tok_res   = classify(cands_r, pend_len_r, all_dig_r, dig_dot_r, seen_dot_r,
                           first_dig_r, pend_start_r);
    end else begin
      tok_valid = in_data.end_of_line;
      tok_res   = classify(upd_cands, upd_len, upd_all_dig, upd_dig_dot, upd_seen_dot,
                           upd_first_dig, upd_start);
    end
    op_res.kind           = KIND_OPERATOR;
    op_res.token_start    = line_pos_r;
    op_res.token_length   = 8'd1;
    op_res.keyword_number = '0;
    op_res.last_result    = 1'b1;
  end

  always_comb begin
    q_entry.two               = tok_valid && oper;
    q_entry.res_a             = tok_valid ? tok_res : op_res;
    q_entry.res_a.last_result = !(tok_valid && oper);
    q_entry.res_b             = op_res;
    q_push                    = accept && (tok_valid || oper);
  end

  always_comb begin
    line_pos_nxt   = line_pos_r;
    pend_start_nxt = pend_start_r;
    pend_len_nxt   = pend_len_r;
    all_dig_nxt    = all_dig_r;
    dig_dot_nxt    = dig_dot_r;
    seen_dot_nxt   = seen_dot_r;
    first_dig_nxt  = first_dig_r;
    cands_nxt      = cands_r;
    if (accept) begin
      if (!delim) begin
        pend_start_nxt = upd_start;
        pend_len_nxt   = upd_len;
        all_dig_nxt    = upd_all_dig;
        dig_dot_nxt    = upd_dig_dot;
        seen_dot_nxt   = upd_seen_dot;
        first_dig_nxt  = upd_first_dig;
        cands_nxt      = upd_cands;
      end
      // drop the token once it is closed
      if (in_data.end_of_line || (delim && pend_len_r != '0)) begin
        pend_start_nxt = '0;
        pend_len_nxt   = '0;
        all_dig_nxt    = 1'b1;
        dig_dot_nxt    = 1'b1;
        seen_dot_nxt   = 1'b0;
        first_dig_nxt  = 1'b0;
        cands_nxt      = ALL_CANDS;
      end
      if (in_data.end_of_line) line_pos_nxt = '0;
      else if (line_pos_r < POS_CAP) line_pos_nxt = line_pos_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r   <= '0;
      pend_start_r <= '0;
      pend_len_r   <= '0;
      all_dig_r    <= 1'b1;
      dig_dot_r    <= 1'b1;
      seen_dot_r   <= 1'b0;
      first_dig_r  <= 1'b0;
      cands_r      <= ALL_CANDS;
    end else begin
      line_pos_r   <= line_pos_nxt;
      pend_start_r <= pend_start_nxt;
      pend_len_r   <= pend_len_nxt;
      all_dig_r    <= all_dig_nxt;
      dig_dot_r    <= dig_dot_nxt;
      seen_dot_r   <= seen_dot_nxt;
      first_dig_r  <= first_dig_nxt;
      cands_r      <= cands_nxt;
    end
  end

endmodule

### rtl/stc_queue.sv
// Short result queue between the front end and the output sequencer.
// Depends on stc_pkg for the entry type and depth.
module stc_queue
  import stc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output q_head_t  head
);

  q_entry_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               do_pop;

  assign full       = count_r == (Q_PTR_W + 1)'(Q_DEPTH);
  assign do_pop     = pop && count_r != '0;
  assign head.valid = count_r != '0;
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (Q_PTR_W + 1)'(push) - (Q_PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/stc_back.sv
// Output sequencer: sends one or two result beats per queue entry.
// Depends on stc_pkg; reads the head of stc_queue.
module stc_back
  import stc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_head_t head,
  input  logic    out_stall,
  output logic    out_valid,
  output res_t    out_data,
  output logic    pop
);

  logic phase_r, phase_nxt;
  logic beat, final_beat;

  assign out_valid  = head.valid;
  assign out_data   = phase_r ? head.entry.res_b : head.entry.res_a;
  assign beat       = head.valid && !out_stall;
  assign final_beat = phase_r || !head.entry.two;
  assign pop        = beat && final_beat;

  always_comb begin
    phase_nxt = phase_r;
    if (beat) phase_nxt = !final_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= 1'b0;
    else        phase_r <= phase_nxt;
  end

endmodule

### rtl/source_token_classifier.sv
// Top level of the source token classifier: front end, result queue, output sequencer.
// Depends on stc_pkg, stc_front, stc_queue and stc_back.
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+--------------------------------
//   in_     | input     | in_t    | in_valid / in_stall (driven here)
//   out_    | output    | res_t   | out_valid / out_stall (driven by sink)
//
// One character beat is taken per cycle while in_stall is low; the front end classifies it in the
// cycle it arrives and writes all its results as one entry of a four-entry queue.
// A result reaches out_ only after its entry is registered in the queue; a
// character that closes a token with an operator holds the output two beats.
// in_stall rises only while the queue is full, so output stalls reach the input
// after four pending entries.
// Reset (rst_n low, synchronous) clears line position, token state and the queue.
module source_token_classifier
  import stc_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_data,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  // line position stops at the smaller of MAX_LINE-1 and 255
  localparam int          POS_CAP_I = (MAX_LINE - 1 < 255) ? MAX_LINE - 1 : 255;
  localparam logic [7:0]  POS_CAP   = 8'(POS_CAP_I);

  logic     q_push, q_full, q_pop;
  q_entry_t q_entry;
  q_head_t  q_head;

  // front end: classify and enqueue
  stc_front #(
    .POS_CAP (POS_CAP)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // decouple the two sides
  stc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head       (q_head)
  );

  // back end: advance through one or two beats per entry
  stc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .pop       (q_pop)
  );

  // never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("push while queue full");

  // an entry leaves only with the final beat of its results
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (out_valid && !out_stall && out_data.last_result))
    else $error("pop without final beat");

  // a non-final beat is followed by the final operator beat of the same entry
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_result) |=>
      (out_valid && out_data.last_result && out_data.kind == KIND_OPERATOR))
    else $error("second result missing");

  // keyword number is zero for every other kind
  a_kwn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != KIND_KEYWORD) |-> out_data.keyword_number == '0)
    else $error("keyword number on non-keyword");

endmodule
